[src/tpvu_pkg.sv]
`default_nettype none

package tpvu_pkg;

   // Fixed-point formats.
   localparam int FRACTION_BITS      = 8;
   localparam int SINE_FRACTION_BITS = 14;
   localparam int TABLE_BITS         = 14;

   // Field widths.
   localparam int ACTION_W = 4;
   localparam int PIX_W    = 16;
   localparam int POS_W    = 24;
   localparam int HEAD_W   = 9;
   localparam int COLOR_W  = 16;
   localparam int HOME_W   = 15;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_HOME_X = 1'b0;
   localparam logic REG_HOME_Y = 1'b1;
   localparam logic [HOME_W-1:0] HOME_X_RESET = 15'd160;
   localparam logic [HOME_W-1:0] HOME_Y_RESET = 15'd120;

   // Command codes.
   localparam logic [ACTION_W-1:0] ACT_GOTO       = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_SETX       = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_SETY       = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_PENUP      = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_PENDOWN    = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_SETHEADING = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_RIGHT      = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_LEFT       = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_FORWARD    = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_HOME       = 4'd9;
   localparam logic [ACTION_W-1:0] ACT_COLOR      = 4'd10;
   localparam logic [ACTION_W-1:0] ACT_RESET      = 4'd11;

   // Angles.
   localparam int DEG_QUARTER = 90;
   localparam int DEG_FULL    = 360;
   localparam int TABLE_LAST  = DEG_QUARTER;

   // Heading modulo: bias the sum positive, then multiply by a reciprocal of 360.
   localparam int MOD_W       = 17;
   localparam int MOD_BIAS    = DEG_FULL * 92;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = 14;
   localparam logic [RECIP_W-1:0] RECIP = 14'd11651;
   localparam int MOD_Q_W     = 8;
   localparam int MOD_P_W     = MOD_W + RECIP_W;

   // Sine magnitude and forward step widths.
   localparam int SINE_W    = SINE_FRACTION_BITS + 1;
   localparam int SINE_UP   = (SINE_FRACTION_BITS >= TABLE_BITS) ?
                              SINE_FRACTION_BITS - TABLE_BITS : 0;
   localparam int SINE_DN   = (SINE_FRACTION_BITS < TABLE_BITS) ?
                              TABLE_BITS - SINE_FRACTION_BITS : 0;
   localparam int STEP_UP   = (FRACTION_BITS >= SINE_FRACTION_BITS) ?
                              FRACTION_BITS - SINE_FRACTION_BITS : 0;
   localparam int STEP_DN   = (SINE_FRACTION_BITS > FRACTION_BITS) ?
                              SINE_FRACTION_BITS - FRACTION_BITS : 0;
   localparam int PROD_W    = PIX_W + SINE_W;
   localparam int STEP_W    = PROD_W + STEP_UP + 1;
   localparam int SUM_W     = STEP_W + 2;
   localparam int POS_MAX   = 2 ** (POS_W - 1) - 1;
   localparam int POS_MIN   = -(2 ** (POS_W - 1));
   localparam int PIX_MAX   = 2 ** (PIX_W - 1) - 1;
   localparam int PIX_MIN   = -(2 ** (PIX_W - 1));

   localparam logic [TABLE_BITS:0] QUARTER_SINE [0:TABLE_LAST] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic signed [PIX_W-1:0] coord_x;
      logic signed [PIX_W-1:0] coord_y;
      logic signed [PIX_W-1:0] angle;
      logic signed [PIX_W-1:0] distance;
      logic [COLOR_W-1:0]      color_value;
   } req_type;

   typedef struct packed {
      logic                    line_valid;
      logic signed [PIX_W-1:0] line_x0;
      logic signed [PIX_W-1:0] line_y0;
      logic signed [PIX_W-1:0] line_x1;
      logic signed [PIX_W-1:0] line_y1;
      logic [COLOR_W-1:0]      line_color;
      logic signed [POS_W-1:0] position_x;
      logic signed [POS_W-1:0] position_y;
      logic [HEAD_W-1:0]       heading_out;
      logic                    pen_is_down;
   } rsp_type;

   // Sine magnitude for 0..90 degrees in the working sine format.
   function automatic logic [SINE_W-1:0] sine_mag(input logic [6:0] deg);
      logic [31:0] v;
      v = (deg > 7'(TABLE_LAST)) ? 32'd0 : 32'(QUARTER_SINE[deg]);
      v = v << SINE_UP;
      v = (v + ((32'd1 << SINE_DN) >> 1)) >> SINE_DN;
      return v[SINE_W-1:0];
   endfunction

   // Sign and magnitude of sin(h) for a heading of 0..359 degrees.
   function automatic logic [SINE_W:0] sine_of(input logic [HEAD_W-1:0] h);
      logic [HEAD_W-1:0] r;
      logic [1:0]        q;
      logic [6:0]        idx;
      if (h >= HEAD_W'(3 * DEG_QUARTER)) begin
         q = 2'd3;
         r = h - HEAD_W'(3 * DEG_QUARTER);
      end else if (h >= HEAD_W'(2 * DEG_QUARTER)) begin
         q = 2'd2;
         r = h - HEAD_W'(2 * DEG_QUARTER);
      end else if (h >= HEAD_W'(DEG_QUARTER)) begin
         q = 2'd1;
         r = h - HEAD_W'(DEG_QUARTER);
      end else begin
         q = 2'd0;
         r = h;
      end
      idx = q[0] ? 7'(HEAD_W'(DEG_QUARTER) - r) : r[6:0];
      return {q[1], sine_mag(idx)};
   endfunction

   // Saturate a wide position value to the position range.
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(POS_MAX);
      lo = SUM_W'(POS_MIN);
      if (v > hi) begin
         return hi[POS_W-1:0];
      end else if (v < lo) begin
         return lo[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

[src/turtle_pen_vector_unit_top.sv]
`default_nettype none

// Turtle pen unit. Each item on the req_ channel is one pen command (go to, set x,
// set y, pen up, pen down, set heading, turn right, turn left, forward, home, set
// color, reset), and each command returns exactly one item on the rsp_ channel with
// the position, heading and pen state after the command, plus a line segment when a
// move is made with the pen down. Positions are signed 24-bit values with 8 fraction
// bits and saturate at the ends of their range; segment ends are whole pixels,
// truncated toward zero. An item passes through an input register and a result
// register, from which its result is offered on the rsp_ channel. A new item can be
// accepted in every cycle for a sustained rate of one item per clock while the rsp_
// channel is not stalled. The longest path per item is the sine table lookup
// feeding a 16 by 15 bit multiply and the saturating add of the forward move, and
// in parallel the reciprocal multiply of the heading modulo. Home coordinates are
// written through the register port (home_x at byte address 0, home_y at 4); the
// user must write them only while the unit is idle; the unit does not enforce it.
module turtle_pen_vector_unit_top import tpvu_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // Convert a whole pixel to the position format, saturating.
   function automatic logic signed [POS_W-1:0] pixel_to_pos(
      input logic signed [PIX_W-1:0] p);
      logic signed [SUM_W-1:0] w;
      w = SUM_W'(p);
      w = w <<< FRACTION_BITS;
      return sat_pos(w);
   endfunction

   // Whole pixel of a position, truncated toward zero and clamped.
   function automatic logic signed [PIX_W-1:0] pos_to_pixel(
      input logic signed [POS_W-1:0] v);
      logic [POS_W-1:0]      mag;
      logic signed [POS_W:0] s;
      mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
      mag = mag >> FRACTION_BITS;
      s   = v[POS_W-1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      if (s > (POS_W+1)'(PIX_MAX)) begin
         return PIX_W'(PIX_MAX);
      end else if (s < (POS_W+1)'(PIX_MIN)) begin
         return PIX_W'(PIX_MIN);
      end
      return s[PIX_W-1:0];
   endfunction

   // distance * sin, scaled to the position format, rounding half away from zero.
   function automatic logic signed [SUM_W-1:0] scaled_step(
      input logic signed [PIX_W-1:0] travel,
      input logic [SINE_W:0]         sine);
      logic [PIX_W-1:0]  dmag;
      logic [PROD_W-1:0] prod;
      logic [STEP_W-1:0] m;
      logic              neg;
      dmag = travel[PIX_W-1] ? (~travel + 1'b1) : travel;
      prod = dmag * sine[SINE_W-1:0];
      m    = STEP_W'(prod) << STEP_UP;
      m    = (m + STEP_W'((2 ** STEP_DN) / 2)) >> STEP_DN;
      neg  = travel[PIX_W-1] ^ sine[SINE_W];
      return neg ? -signed'(SUM_W'(m)) : signed'(SUM_W'(m));
   endfunction

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Result register.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // Pen state.
   logic signed [POS_W-1:0] x_ff, x_in;
   logic signed [POS_W-1:0] y_ff, y_in;
   logic [HEAD_W-1:0]       heading_ff, heading_in;
   logic                    pen_ff, pen_in;
   logic [COLOR_W-1:0]      color_ff, color_in;

   // Configuration registers.
   logic [HOME_W-1:0] home_x_ff, home_x_in;
   logic [HOME_W-1:0] home_y_ff, home_y_in;

   logic advance;
   logic fire;
   logic accept;
   logic csr_write;

   // Heading modulo datapath.
   logic signed [MOD_W:0]  head_sum;
   logic [MOD_W-1:0]       mod_v;
   logic [MOD_P_W-1:0]     mod_p;
   logic [MOD_Q_W-1:0]     mod_q;
   logic [MOD_W-1:0]       mod_r;
   logic [HEAD_W-1:0]      head_mod;

   // Forward move datapath.
   logic [HEAD_W:0]         cos_sum;
   logic [HEAD_W-1:0]       cos_head;
   logic signed [SUM_W-1:0] step_x;
   logic signed [SUM_W-1:0] step_y;
   logic signed [POS_W-1:0] fwd_x;
   logic signed [POS_W-1:0] fwd_y;
   logic signed [POS_W-1:0] home_px;
   logic signed [POS_W-1:0] home_py;

   logic moved;
   logic draw;

   // The pipeline moves when the result register is empty or being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Register port. Only bit 2 of the address selects a register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign home_x_in = (csr_write && paddr[2] == REG_HOME_X) ? pwdata[HOME_W-1:0] : home_x_ff;
   assign home_y_in = (csr_write && paddr[2] == REG_HOME_Y) ? pwdata[HOME_W-1:0] : home_y_ff;
   assign prdata    = (paddr[2] == REG_HOME_Y) ? CSR_DATA_W'(home_y_ff)
                                               : CSR_DATA_W'(home_x_ff);

   // Heading modulo 360. The biased sum is always positive and below 2^17, where
   // the reciprocal quotient is exact; the final compare covers any off-by-one.
   always_comb begin
      case (in_data_ff.action)
         ACT_RIGHT: head_sum = signed'((MOD_W+1)'(heading_ff))
                               + (MOD_W+1)'(in_data_ff.angle);
         ACT_LEFT:  head_sum = signed'((MOD_W+1)'(heading_ff))
                               - (MOD_W+1)'(in_data_ff.angle);
         default:   head_sum = (MOD_W+1)'(in_data_ff.angle);
      endcase
      mod_v = MOD_W'(head_sum + (MOD_W+1)'(MOD_BIAS));
      mod_p = mod_v * RECIP;
      mod_q = MOD_Q_W'(mod_p >> RECIP_SHIFT);
      mod_r = mod_v - MOD_W'(MOD_W'(mod_q) * MOD_W'(DEG_FULL));
      head_mod = (mod_r >= MOD_W'(DEG_FULL)) ? HEAD_W'(mod_r - MOD_W'(DEG_FULL))
                                             : HEAD_W'(mod_r);
   end

   // Forward move: x gains dist*sin(h), y loses dist*sin(h+90).
   always_comb begin
      cos_sum  = (HEAD_W+1)'(heading_ff) + (HEAD_W+1)'(DEG_QUARTER);
      cos_head = (cos_sum >= (HEAD_W+1)'(DEG_FULL)) ?
                 HEAD_W'(cos_sum - (HEAD_W+1)'(DEG_FULL)) : HEAD_W'(cos_sum);
      step_x   = scaled_step(in_data_ff.distance, sine_of(heading_ff));
      step_y   = scaled_step(in_data_ff.distance, sine_of(cos_head));
      fwd_x    = sat_pos(SUM_W'(x_ff) + step_x);
      fwd_y    = sat_pos(SUM_W'(y_ff) - step_y);
      home_px  = pixel_to_pos(signed'({1'b0, home_x_ff}));
      home_py  = pixel_to_pos(signed'({1'b0, home_y_ff}));
   end

   // Command decode and next state.
   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      heading_in = heading_ff;
      pen_in     = pen_ff;
      color_in   = color_ff;
      moved      = 1'b0;
      case (in_data_ff.action)
         ACT_GOTO: begin
            x_in  = pixel_to_pos(in_data_ff.coord_x);
            y_in  = pixel_to_pos(in_data_ff.coord_y);
            moved = 1'b1;
         end
         ACT_SETX: begin
            x_in  = pixel_to_pos(in_data_ff.coord_x);
            moved = 1'b1;
         end
         ACT_SETY: begin
            y_in  = pixel_to_pos(in_data_ff.coord_y);
            moved = 1'b1;
         end
         ACT_PENUP:      pen_in = 1'b0;
         ACT_PENDOWN:    pen_in = 1'b1;
         ACT_SETHEADING: heading_in = head_mod;
         ACT_RIGHT:      heading_in = head_mod;
         ACT_LEFT:       heading_in = head_mod;
         ACT_FORWARD: begin
            x_in  = fwd_x;
            y_in  = fwd_y;
            moved = 1'b1;
         end
         ACT_HOME: begin
            x_in  = home_px;
            y_in  = home_py;
            moved = 1'b1;
         end
         ACT_COLOR: color_in = in_data_ff.color_value;
         ACT_RESET: begin
            // Jump home without drawing and leave the pen down; the color is kept.
            x_in       = home_px;
            y_in       = home_py;
            heading_in = '0;
            pen_in     = 1'b1;
         end
         default: begin
         end
      endcase

      // Moves never change the pen, so the current pen state decides drawing.
      draw = moved && pen_ff;

      out_data_in.line_valid  = draw;
      out_data_in.line_x0     = draw ? pos_to_pixel(x_ff) : '0;
      out_data_in.line_y0     = draw ? pos_to_pixel(y_ff) : '0;
      out_data_in.line_x1     = draw ? pos_to_pixel(x_in) : '0;
      out_data_in.line_y1     = draw ? pos_to_pixel(y_in) : '0;
      out_data_in.line_color  = draw ? color_ff : '0;
      out_data_in.position_x  = x_in;
      out_data_in.position_y  = y_in;
      out_data_in.heading_out = heading_in;
      out_data_in.pen_is_down = pen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
         pen_ff       <= 1'b0;
         color_ff     <= '0;
         home_x_ff    <= HOME_X_RESET;
         home_y_ff    <= HOME_Y_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         home_x_ff    <= home_x_in;
         home_y_ff    <= home_y_in;
         if (fire) begin
            x_ff       <= x_in;
            y_ff       <= y_in;
            heading_ff <= heading_in;
            pen_ff     <= pen_in;
            color_ff   <= color_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

[src/tpvu_checker.sv]
`default_nettype none

module tpvu_checker import tpvu_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire req_type               req_data,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rsp_type               rsp_data,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [CSR_DATA_W-1:0] pwdata,
   input wire logic [CSR_DATA_W-1:0] prdata,
   input wire logic                  pready
);

   // A result that is held back stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The heading is always reduced to one turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading_out < HEAD_W'(DEG_FULL))
      else $error("heading out of range");

   // A segment is only drawn with the pen down.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_valid |-> rsp_data.pen_is_down)
      else $error("line drawn with pen up");

   // Without a segment the line fields read zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.line_valid |->
         rsp_data.line_x0 == '0 && rsp_data.line_y0 == '0 &&
         rsp_data.line_x1 == '0 && rsp_data.line_y1 == '0 &&
         rsp_data.line_color == '0)
      else $error("line fields set without a line");

endmodule

bind turtle_pen_vector_unit_top tpvu_checker u_tpvu_checker (.*);

`default_nettype wire
